// ===== rtl/cft_pkg.sv =====
`default_nettype none
package cft_pkg;

    localparam int TABLE_ENTRIES_DEF = 16;

    localparam int OP_W     = 2;
    localparam int ADDR_W   = 32;
    localparam int PORT_W   = 16;
    localparam int TIME_W   = 32;
    localparam int CNT_W    = 32;
    localparam int STATUS_W = 3;
    localparam int SLOT_W   = 4;
    localparam int FREED_W  = 5;

    // wide enough for any table size in range (up to 256 entries)
    localparam int SLOT_MAX_W = 8;

    localparam logic [OP_W-1:0] OP_MESSAGE = 2'd0;
    localparam logic [OP_W-1:0] OP_CLOSE   = 2'd1;
    localparam logic [OP_W-1:0] OP_SWEEP   = 2'd2;
    localparam logic [OP_W-1:0] OP_UNUSED  = 2'd3;

    localparam logic [STATUS_W-1:0] ST_COUNTED = 3'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 3'd1;
    localparam logic [STATUS_W-1:0] ST_CLOSED  = 3'd2;
    localparam logic [STATUS_W-1:0] ST_NOMATCH = 3'd3;
    localparam logic [STATUS_W-1:0] ST_SWEPT   = 3'd4;

    localparam logic [TIME_W-1:0] AGE_LIMIT_RESET = 32'd60;

    // travels from cell to cell: first match and first free slot so far
    typedef struct packed {
        logic                  hit;
        logic [SLOT_MAX_W-1:0] hit_slot;
        logic [CNT_W-1:0]      hit_count;
        logic                  free;
        logic [SLOT_MAX_W-1:0] open_slot;
    } chain_t;

    // broadcast from the controller to every cell
    typedef struct packed {
        logic              go;
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] age_limit;
        logic              miss;
    } cmd_t;

endpackage
`default_nettype wire

// ===== rtl/cft_item_if.sv =====
`default_nettype none
interface cft_item_if import cft_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [ADDR_W-1:0] client_addr;
    logic [PORT_W-1:0] peer_port;
    logic [TIME_W-1:0] now;

    modport source (output valid, output op, output client_addr, output peer_port,
                    output now, input ready);
    modport sink   (input valid, input op, input client_addr, input peer_port,
                    input now, output ready);
endinterface
`default_nettype wire

// ===== rtl/cft_result_if.sv =====
`default_nettype none
interface cft_result_if import cft_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   slot;
    logic [CNT_W-1:0]    count;
    logic [FREED_W-1:0]  freed;

    modport source (output valid, output status, output slot, output count,
                    output freed, input ready);
    modport sink   (input valid, input status, input slot, input count,
                    input freed, output ready);
endinterface
`default_nettype wire

// ===== rtl/cft_cfg_if.sv =====
`default_nettype none
interface cft_cfg_if import cft_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [TIME_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

// ===== rtl/cft_cell.sv =====
`default_nettype none
module cft_cell import cft_pkg::*; #(
    parameter logic [SLOT_MAX_W-1:0] CELL_IDX = '0
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    input  wire cmd_t   cmd,
    input  wire chain_t chain_in,
    output chain_t      chain_out,
    output logic        aged
);

    logic              valid_reg, valid_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [PORT_W-1:0] port_reg, port_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [TIME_W-1:0] seen_reg, seen_next;

    logic             match;
    logic             first_hit;
    logic             first_free;
    logic [CNT_W-1:0] count_inc;
    logic [TIME_W-1:0] age;

    assign match      = valid_reg && (addr_reg == cmd.addr) && (port_reg == cmd.port);
    assign first_hit  = match && !chain_in.hit;
    assign first_free = !valid_reg && !chain_in.free;
    assign count_inc  = (count_reg == {CNT_W{1'b1}}) ? count_reg : count_reg + 1'b1;
    assign age        = cmd.now - seen_reg;
    assign aged       = valid_reg && (age > cmd.age_limit);

    always_comb
    begin
        chain_out = chain_in;
        if (first_hit)
        begin
            chain_out.hit       = 1'b1;
            chain_out.hit_slot  = CELL_IDX;
            chain_out.hit_count = count_inc;
        end
        if (first_free)
        begin
            chain_out.free      = 1'b1;
            chain_out.open_slot = CELL_IDX;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        addr_next  = addr_reg;
        port_next  = port_reg;
        count_next = count_reg;
        seen_next  = seen_reg;
        if (cmd.go)
        begin
            case (cmd.op)
                OP_MESSAGE:
                begin
                    if (first_hit)
                    begin
                        seen_next  = cmd.now;
                        count_next = count_inc;
                    end
                    else if (cmd.miss && first_free)
                    begin
                        valid_next = 1'b1;
                        addr_next  = cmd.addr;
                        port_next  = cmd.port;
                        count_next = {{(CNT_W-1){1'b0}}, 1'b1};
                        seen_next  = cmd.now;
                    end
                end
                OP_CLOSE:
                begin
                    if (first_hit)
                        valid_next = 1'b0;
                end
                OP_SWEEP:
                begin
                    if (aged)
                        valid_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        addr_reg  <= addr_next;
        port_reg  <= port_next;
        count_reg <= count_next;
        seen_reg  <= seen_next;
    end

endmodule
`default_nettype wire

// ===== rtl/client_flow_table_with_aging.sv =====
`default_nettype none
// Client flow table with aging. Each table entry is a cell holding key (address, port),
// message count and last-seen time; cells form a chain that carries the first match
// and the first free slot from entry 0 upward. An item is taken on req into the input
// registers, then evaluated in state S_EVAL against all entries in one pass through the
// cell chain, and its result is loaded into the rsp register. A new item is accepted
// while the previous result still waits on rsp; evaluation then holds until that result
// is taken. No new item is taken during S_EVAL. Op code 3 gives no result. The age
// limit is written through cfg (always ready) and resets to 60.
module client_flow_table_with_aging import cft_pkg::*; #(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
) (
    input  wire logic    clk,
    input  wire logic    rst_n,
    cft_item_if.sink     req,
    cft_result_if.source rsp,
    cft_cfg_if.sink      cfg
);

    localparam int AGED_CNT_W = $clog2(TABLE_ENTRIES + 1);

    typedef enum logic {
        S_IDLE,
        S_EVAL
    } state_t;

    state_t              state_reg, state_next;
    logic [OP_W-1:0]     op_reg, op_next;
    logic [ADDR_W-1:0]   addr_reg, addr_next;
    logic [PORT_W-1:0]   port_reg, port_next;
    logic [TIME_W-1:0]   now_reg, now_next;
    logic [TIME_W-1:0]   age_limit_reg, age_limit_next;
    logic                out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [FREED_W-1:0]  freed_reg, freed_next;

    chain_t                  chain [TABLE_ENTRIES+1];
    logic [TABLE_ENTRIES-1:0] aged;
    cmd_t                    cmd;
    logic                    out_free;
    logic                    go;
    logic [AGED_CNT_W-1:0]   aged_cnt;
    chain_t                  chain_end;

    assign chain[0]  = '0;
    assign chain_end = chain[TABLE_ENTRIES];

    genvar gi;
    generate
        for (gi = 0; gi < TABLE_ENTRIES; gi++)
        begin : g_cell
            cft_cell #(
                .CELL_IDX (SLOT_MAX_W'(gi))
            ) u_cell (
                .clk       (clk),
                .rst_n     (rst_n),
                .cmd       (cmd),
                .chain_in  (chain[gi]),
                .chain_out (chain[gi+1]),
                .aged      (aged[gi])
            );
        end
    endgenerate

    assign out_free = !out_valid_reg || rsp.ready;
    assign go       = (state_reg == S_EVAL) && out_free && (op_reg != OP_UNUSED);
    assign aged_cnt = AGED_CNT_W'($countones(aged));

    always_comb
    begin
        cmd.go        = go;
        cmd.op        = op_reg;
        cmd.addr      = addr_reg;
        cmd.port      = port_reg;
        cmd.now       = now_reg;
        cmd.age_limit = age_limit_reg;
        cmd.miss      = !chain_end.hit;
    end

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = 1'b1;

    assign rsp.valid  = out_valid_reg;
    assign rsp.status = status_reg;
    assign rsp.slot   = slot_reg;
    assign rsp.count  = count_reg;
    assign rsp.freed  = freed_reg;

    always_comb
    begin
        state_next     = state_reg;
        op_next        = op_reg;
        addr_next      = addr_reg;
        port_next      = port_reg;
        now_next       = now_reg;
        age_limit_next = age_limit_reg;
        out_valid_next = out_valid_reg;
        status_next    = status_reg;
        slot_next      = slot_reg;
        count_next     = count_reg;
        freed_next     = freed_reg;

        if (cfg.valid)
            age_limit_next = cfg.data;

        if (out_valid_reg && rsp.ready)
            out_valid_next = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    op_next    = req.op;
                    addr_next  = req.client_addr;
                    port_next  = req.peer_port;
                    now_next   = req.now;
                    state_next = S_EVAL;
                end
            end
            S_EVAL:
            begin
                if (op_reg == OP_UNUSED)
                    state_next = S_IDLE;
                else if (out_free)
                begin
                    state_next     = S_IDLE;
                    out_valid_next = 1'b1;
                    status_next    = ST_COUNTED;
                    slot_next      = '0;
                    count_next     = '0;
                    freed_next     = '0;
                    case (op_reg)
                        OP_MESSAGE:
                        begin
                            if (chain_end.hit)
                            begin
                                slot_next  = chain_end.hit_slot[SLOT_W-1:0];
                                count_next = chain_end.hit_count;
                            end
                            else if (chain_end.free)
                            begin
                                slot_next  = chain_end.open_slot[SLOT_W-1:0];
                                count_next = {{(CNT_W-1){1'b0}}, 1'b1};
                            end
                            else
                                status_next = ST_FULL;
                        end
                        OP_CLOSE:
                        begin
                            if (chain_end.hit)
                            begin
                                status_next = ST_CLOSED;
                                slot_next   = chain_end.hit_slot[SLOT_W-1:0];
                            end
                            else
                                status_next = ST_NOMATCH;
                        end
                        default:
                        begin
                            status_next = ST_SWEPT;
                            freed_next  = FREED_W'(aged_cnt);
                        end
                    endcase
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            op_reg        <= OP_MESSAGE;
            addr_reg      <= '0;
            port_reg      <= '0;
            now_reg       <= '0;
            age_limit_reg <= AGE_LIMIT_RESET;
            out_valid_reg <= 1'b0;
            status_reg    <= ST_COUNTED;
            slot_reg      <= '0;
            count_reg     <= '0;
            freed_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            op_reg        <= op_next;
            addr_reg      <= addr_next;
            port_reg      <= port_next;
            now_reg       <= now_next;
            age_limit_reg <= age_limit_next;
            out_valid_reg <= out_valid_next;
            status_reg    <= status_next;
            slot_reg      <= slot_next;
            count_reg     <= count_next;
            freed_reg     <= freed_next;
        end
    end

endmodule
`default_nettype wire

// ===== sim/tb_top.sv =====
`default_nettype none
module tb_top;
    import cft_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_SLOTS    = TABLE_ENTRIES_DEF;
    localparam int KEY_POOL     = 22;
    localparam int PHASE_ITEMS  = 230;
    localparam int HOLD_CYCLES  = 300;
    localparam int DRAIN_CYCLES = 10;
    localparam int STALL_LIMIT  = 3000;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
        logic [TIME_W-1:0] now;
    } flow_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [CNT_W-1:0]    count;
        logic [FREED_W-1:0]  freed;
    } flow_result_t;

    logic clk;
    logic rst_n;

    cft_item_if   req_if ();
    cft_result_if rsp_if ();
    cft_cfg_if    cfg_if ();

    client_flow_table_with_aging u_top (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if),
        .cfg   (cfg_if)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    // shadow of the flow table
    logic              tbl_valid [NUM_SLOTS];
    logic [ADDR_W-1:0] tbl_addr  [NUM_SLOTS];
    logic [PORT_W-1:0] tbl_port  [NUM_SLOTS];
    logic [CNT_W-1:0]  tbl_count [NUM_SLOTS];
    logic [TIME_W-1:0] tbl_seen  [NUM_SLOTS];
    logic [TIME_W-1:0] aging_limit;

    flow_item_t   pending_items [$];
    flow_result_t flow_results_due [$];

    int          errors = 0;
    bit          no_idle;
    int          hold_requests;
    int          holds_served;
    int unsigned send_gap;
    int unsigned stall_left;
    int unsigned quiet_cycles;

    flow_item_t   next_item;
    flow_result_t predicted;
    bit           has_result;
    flow_result_t got;
    flow_result_t want;

    logic [ADDR_W-1:0] pool_addr [KEY_POOL];
    logic [PORT_W-1:0] pool_port [KEY_POOL];
    logic [TIME_W-1:0] t_now;

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (no_idle)
            return 0;
        if (r < 60)
            return 0;
        if (r < 88)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 10);
        return $urandom_range(15, 40);
    endfunction

    function automatic int find_flow(input logic [ADDR_W-1:0] a, input logic [PORT_W-1:0] p);
        for (int k = 0; k < NUM_SLOTS; k++)
            if (tbl_valid[k] && tbl_addr[k] == a && tbl_port[k] == p)
                return k;
        return -1;
    endfunction

    task automatic clear_entry(input int k);
        tbl_valid[k] = 1'b0;
        tbl_addr[k]  = '0;
        tbl_port[k]  = '0;
        tbl_count[k] = '0;
        tbl_seen[k]  = '0;
    endtask

    task automatic update_flow_table(input flow_item_t it, output bit produces,
                                     output flow_result_t r);
        int                k;
        int unsigned       swept;
        logic [TIME_W-1:0] age;
        produces = 1'b1;
        r = '0;
        swept = 0;
        case (it.op)
            OP_MESSAGE:
            begin
                k = find_flow(it.addr, it.port);
                if (k < 0)
                begin
                    for (int j = NUM_SLOTS - 1; j >= 0; j--)
                        if (!tbl_valid[j])
                            k = j;
                    if (k >= 0)
                    begin
                        tbl_valid[k] = 1'b1;
                        tbl_addr[k]  = it.addr;
                        tbl_port[k]  = it.port;
                        tbl_count[k] = '0;
                    end
                end
                if (k < 0)
                    r.status = ST_FULL;
                else
                begin
                    tbl_seen[k] = it.now;
                    if (tbl_count[k] != '1)
                        tbl_count[k] = tbl_count[k] + 1'b1;
                    r.status = ST_COUNTED;
                    r.slot   = k[SLOT_W-1:0];
                    r.count  = tbl_count[k];
                end
            end
            OP_CLOSE:
            begin
                k = find_flow(it.addr, it.port);
                if (k < 0)
                    r.status = ST_NOMATCH;
                else
                begin
                    clear_entry(k);
                    r.status = ST_CLOSED;
                    r.slot   = k[SLOT_W-1:0];
                end
            end
            OP_SWEEP:
            begin
                for (int j = 0; j < NUM_SLOTS; j++)
                begin
                    age = it.now - tbl_seen[j];
                    if (tbl_valid[j] && age > aging_limit)
                    begin
                        clear_entry(j);
                        swept++;
                    end
                end
                r.status = ST_SWEPT;
                r.freed  = swept[FREED_W-1:0];
            end
            default:
                produces = 1'b0;
        endcase
    endtask

    // driver: feeds the request channel from pending_items and predicts on acceptance
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_if.valid       <= 1'b0;
            req_if.op          <= OP_MESSAGE;
            req_if.client_addr <= '0;
            req_if.peer_port   <= '0;
            req_if.now         <= '0;
            send_gap           <= 0;
            for (int k = 0; k < NUM_SLOTS; k++)
                clear_entry(k);
        end
        else
        begin
            if (req_if.valid && req_if.ready)
            begin
                update_flow_table(flow_item_t'{req_if.op, req_if.client_addr,
                                               req_if.peer_port, req_if.now},
                                  has_result, predicted);
                if (has_result)
                    flow_results_due.push_back(predicted);
            end
            if (!req_if.valid || req_if.ready)
            begin
                if (send_gap != 0)
                begin
                    send_gap     <= send_gap - 1;
                    req_if.valid <= 1'b0;
                end
                else if (pending_items.size() != 0)
                begin
                    next_item = pending_items.pop_front();
                    req_if.valid       <= 1'b1;
                    req_if.op          <= next_item.op;
                    req_if.client_addr <= next_item.addr;
                    req_if.peer_port   <= next_item.port;
                    req_if.now         <= next_item.now;
                    send_gap           <= pick_gap();
                end
                else
                    req_if.valid <= 1'b0;
            end
        end
    end

    // monitor: random back-pressure on the result channel, checks every result
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            stall_left   <= 0;
            holds_served <= 0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                got = flow_result_t'{rsp_if.status, rsp_if.slot, rsp_if.count, rsp_if.freed};
                if (flow_results_due.size() == 0)
                begin
                    $error("result with nothing expected: status=%0d slot=%0d count=%0d freed=%0d",
                           got.status, got.slot, got.count, got.freed);
                    errors++;
                end
                else
                begin
                    want = flow_results_due.pop_front();
                    if (got.status !== want.status)
                    begin
                        $error("status: expected %0d, got %0d", want.status, got.status);
                        errors++;
                    end
                    if (got.slot !== want.slot)
                    begin
                        $error("slot: expected %0d, got %0d", want.slot, got.slot);
                        errors++;
                    end
                    if (got.count !== want.count)
                    begin
                        $error("count: expected %0h, got %0h", want.count, got.count);
                        errors++;
                    end
                    if (got.freed !== want.freed)
                    begin
                        $error("freed: expected %0d, got %0d", want.freed, got.freed);
                        errors++;
                    end
                end
            end
            if (holds_served != hold_requests)
            begin
                holds_served <= holds_served + 1;
                stall_left   <= HOLD_CYCLES;
                rsp_if.ready <= 1'b0;
            end
            else if (stall_left != 0)
            begin
                stall_left   <= stall_left - 1;
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
                stall_left   <= pick_gap();
            end
        end
    end

    // watchdog on cycles with no handshake anywhere
    always @(posedge clk)
    begin
        if (!rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)
            || (cfg_if.valid && cfg_if.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    task automatic push_item(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] a,
                             input logic [PORT_W-1:0] p, input logic [TIME_W-1:0] t);
        pending_items.push_back(flow_item_t'{op, a, p, t});
    endtask

    task automatic write_age_limit(input logic [TIME_W-1:0] v);
        @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= v;
        do
            @(posedge clk);
        while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        aging_limit = v;
    endtask

    task automatic wait_idle();
        while (pending_items.size() != 0 || req_if.valid || flow_results_due.size() != 0)
            @(posedge clk);
        // op 3 items leave nothing to wait on, give the block time to settle
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic build_key_pool();
        pool_addr[0] = '0;
        pool_port[0] = '0;
        pool_addr[1] = '1;
        pool_port[1] = '1;
        for (int k = 2; k < KEY_POOL; k++)
        begin
            pool_addr[k] = $urandom();
            pool_port[k] = 16'($urandom_range(0, 65535));
            // keys that differ only in port or only in address
            if (k % 4 == 0)
                pool_addr[k] = pool_addr[k-1];
            else if (k % 4 == 1)
                pool_port[k] = pool_port[k-1];
        end
    endtask

    task automatic push_random_item();
        int unsigned sel;
        int unsigned k;
        sel = $urandom_range(0, 99);
        k = $urandom_range(0, KEY_POOL - 1);
        if ($urandom_range(0, 49) == 0)
            t_now = $urandom();
        else if ($urandom_range(0, 29) == 0)
            t_now = t_now + $urandom();
        else
            t_now = t_now + $urandom_range(0, 6);
        if (sel < 70)
            push_item(OP_MESSAGE, pool_addr[k], pool_port[k], t_now);
        else if (sel < 75)
            push_item(OP_MESSAGE, $urandom(), 16'($urandom_range(0, 65535)), t_now);
        else if (sel < 85)
            push_item(OP_CLOSE, pool_addr[k], pool_port[k], t_now);
        else if (sel < 87)
            push_item(OP_CLOSE, $urandom(), 16'($urandom_range(0, 65535)), t_now);
        else if (sel < 97)
            push_item(OP_SWEEP, $urandom(), 16'($urandom_range(0, 65535)), t_now);
        else
            push_item(OP_UNUSED, $urandom(), 16'($urandom_range(0, 65535)), t_now);
    endtask

    initial
    begin
        logic [TIME_W-1:0] tb;
        logic [TIME_W-1:0] limits [6];

        rst_n              = 1'b0;
        cfg_if.valid       = 1'b0;
        cfg_if.data        = '0;
        no_idle            = 1'b0;
        hold_requests      = 0;
        aging_limit        = AGE_LIMIT_RESET;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // directed: times start just below the wrap point
        tb = 32'hFFFF_FFC0;
        push_item(OP_MESSAGE, 32'h0000_0000, 16'h0000, tb);
        push_item(OP_MESSAGE, 32'hFFFF_FFFF, 16'hFFFF, tb + 10);
        push_item(OP_MESSAGE, 32'h0000_0000, 16'h0000, tb + 20);
        push_item(OP_CLOSE,   32'hFFFF_FFFF, 16'h0000, tb + 21);
        push_item(OP_UNUSED,  32'h5A5A_5A5A, 16'h1234, tb + 22);
        push_item(OP_CLOSE,   32'h0000_0000, 16'h0000, tb + 23);
        push_item(OP_MESSAGE, 32'hFFFF_FFFF, 16'h0000, tb + 24);
        push_item(OP_MESSAGE, 32'h0000_0000, 16'hFFFF, tb + 25);
        for (int k = 0; k < 13; k++)
            push_item(OP_MESSAGE, 32'(32'h0A00_0000 + k), 16'(1000 + k), 32'(tb + 30 + k));
        // table now full
        push_item(OP_MESSAGE, 32'h0B00_0000, 16'd7, tb + 50);
        // sweeps after the time wrapped past zero
        push_item(OP_SWEEP, '0, '0, tb + 80);
        push_item(OP_SWEEP, '0, '0, tb + 91);
        push_item(OP_MESSAGE, 32'h0B00_0000, 16'd7, tb + 92);
        wait_idle();

        t_now = tb + 100;
        limits[0] = 32'd0;
        limits[1] = 32'hFFFF_FFFF;
        limits[2] = 32'd1;
        limits[3] = $urandom_range(10, 200);
        limits[4] = 32'h8000_0000;
        limits[5] = $urandom();
        for (int ph = 0; ph < 6; ph++)
        begin
            write_age_limit(limits[ph]);
            build_key_pool();
            no_idle = (ph == 2);
            if (ph == 3 || ph == 5)
                hold_requests = hold_requests + 1;
            for (int n = 0; n < PHASE_ITEMS; n++)
                push_random_item();
            wait_idle();
        end

        if (errors == 0 && flow_results_due.size() == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
`default_nettype wire

// ===== client_flow_table_with_aging.f =====
rtl/cft_pkg.sv
rtl/cft_item_if.sv
rtl/cft_result_if.sv
rtl/cft_cfg_if.sv
rtl/cft_cell.sv
rtl/client_flow_table_with_aging.sv
sim/tb_top.sv
